// ===== design/assert_macros.svh =====
// Assertion macros included by the rasterizer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Same-cycle implication checked outside reset
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/lspr_pkg.sv =====
// Types and constants of the lidar scan point rasterizer
package lspr_pkg;

    localparam int IMAGE_SIZE_DEF = 500;

    // quarter-wave sine polynomial, Q16
    localparam logic [16:0] SIN_A   = 17'd102944;
    localparam logic [15:0] SIN_B   = 16'd42047;
    localparam logic [12:0] SIN_C   = 13'd4640;
    localparam logic [14:0] QUARTER = 15'd16384;
    localparam logic [16:0] MAG_MAX = 17'd65536;

    localparam int MAG_W = 17;
    localparam int OFF_W = 25;           // (range * mag * scale) >> 32
    localparam int POS_W = OFF_W + 2;    // signed pixel position

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SCALE = 3'd4;

    localparam logic [1:0] STS_PLOT   = 2'd0;
    localparam logic [1:0] STS_REJECT = 2'd1;
    localparam logic [1:0] STS_OFFIMG = 2'd2;
    localparam logic [1:0] STS_RSVD   = 2'd3;

    typedef struct packed {
        logic [15:0] range_mm;
        logic [11:0] sample_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] pixel_x;
        logic [8:0] pixel_y;
    } t_out_item;

endpackage

// ===== design/lspr_sine.sv =====
// Four-stage fixed-point sine magnitude of a 16-bit binary angle
module lspr_sine (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [15:0]                i_angle,
    output logic [lspr_pkg::MAG_W-1:0] o_mag,
    output logic                       o_neg
);

    logic [13:0] w_f;
    logic [14:0] w_x;
    logic [29:0] w_xx;
    logic [27:0] w_t1p;
    logic [15:0] w_d2;
    logic [30:0] w_t2p;
    logic [16:0] w_d3;
    logic [31:0] w_sp;
    logic [17:0] w_s;

    logic [14:0] r2_x, r2_x2;
    logic        r2_neg;
    logic [14:0] r3_x, r3_x2;
    logic [12:0] r3_t1;
    logic        r3_neg;
    logic [14:0] r4_x;
    logic [15:0] r4_t2;
    logic        r4_neg;
    logic [lspr_pkg::MAG_W-1:0] r5_mag;
    logic        r5_neg;

    // fold into first quadrant, x = f or 1 - f (Q14)
    assign w_f   = i_angle[13:0];
    assign w_x   = i_angle[14] ? (lspr_pkg::QUARTER - {1'b0, w_f}) : {1'b0, w_f};
    assign w_xx  = {15'd0, w_x} * {15'd0, w_x};
    assign w_t1p = {15'd0, lspr_pkg::SIN_C} * {13'd0, r2_x2};
    assign w_d2  = lspr_pkg::SIN_B - {3'd0, r3_t1};
    assign w_t2p = {15'd0, w_d2} * {16'd0, r3_x2};
    assign w_d3  = lspr_pkg::SIN_A - {1'b0, r4_t2};
    assign w_sp  = {15'd0, w_d3} * {17'd0, r4_x};
    assign w_s   = w_sp[31:14];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_x   <= w_x;
            r2_x2  <= w_xx[28:14];
            r2_neg <= i_angle[15];
            r3_x   <= r2_x;
            r3_x2  <= r2_x2;
            r3_t1  <= w_t1p[26:14];
            r3_neg <= r2_neg;
            r4_x   <= r3_x;
            r4_t2  <= w_t2p[29:14];
            r4_neg <= r3_neg;
            r5_mag <= (w_s > {1'b0, lspr_pkg::MAG_MAX}) ? lspr_pkg::MAG_MAX : w_s[16:0];
            r5_neg <= r4_neg;
        end
    end

    assign o_mag = r5_mag;
    assign o_neg = r5_neg;

endmodule

// ===== design/lspr_proj.sv =====
// Three-stage projection: range times sine magnitude times pixel scale
module lspr_proj (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [15:0]                i_range,
    input  logic [lspr_pkg::MAG_W-1:0] i_mag,
    input  logic                       i_neg,
    input  logic [23:0]                i_scale,
    output logic [lspr_pkg::OFF_W-1:0] o_off,
    output logic                       o_neg
);

    logic [32:0] w_p1;
    logic [44:0] w_lo, w_hi;
    logic [56:0] w_sum;

    logic [32:0] r6_p1;
    logic        r6_neg;
    logic [44:0] r7_lo, r7_hi;
    logic        r7_neg;
    logic [lspr_pkg::OFF_W-1:0] r8_off;
    logic        r8_neg;

    assign w_p1  = {17'd0, i_range} * {16'd0, i_mag};
    // 33 x 24 product split into two 33 x 12 halves
    assign w_lo  = {12'd0, r6_p1} * {33'd0, i_scale[11:0]};
    assign w_hi  = {12'd0, r6_p1} * {33'd0, i_scale[23:12]};
    assign w_sum = {12'd0, r7_lo} + {r7_hi, 12'd0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_p1  <= w_p1;
            r6_neg <= i_neg;
            r7_lo  <= w_lo;
            r7_hi  <= w_hi;
            r7_neg <= r6_neg;
            r8_off <= w_sum[56:32];
            r8_neg <= r7_neg;
        end
    end

    assign o_off = r8_off;
    assign o_neg = r8_neg;

endmodule

// ===== design/lidar_scan_point_rasterizer_unit.sv =====
// Lidar scan point rasterizer top level: polar range sample to pixel coordinate
//
// Input channel i_valid / o_stall carries one range sample and its beam index;
// output channel o_valid / i_stall carries one result per sample: status,
// pixel_x and pixel_y. A transaction completes when valid is high and stall low.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data); write
// it only while no samples are in flight.
// Throughput: one sample per cycle; the nine-stage pipeline (angle, four sine
// stages per axis, three projection stages, placement) accepts a new sample
// every cycle while the output is not stalled.
// When the receiver stalls a pending result, the whole pipeline freezes and
// o_stall rises; nothing is dropped or duplicated.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads the register
// defaults: full range window, start angle 0, step 182, scale 250.
module lidar_scan_point_rasterizer_unit #(
    parameter int IMAGE_SIZE = lspr_pkg::IMAGE_SIZE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  lspr_pkg::t_in_item                  i_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output lspr_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_we,
    input  logic [lspr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lspr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int STAGES = 8;
    localparam int RNG_DLY = 5;
    localparam int PW = lspr_pkg::POS_W;
    localparam logic signed [PW-1:0] CENTER = PW'(IMAGE_SIZE / 2);
    localparam logic signed [PW-1:0] LIMIT  = PW'(IMAGE_SIZE);

    logic [15:0] r_rmin, r_rmax, r_astart, r_astep;
    logic [23:0] r_scale;

    logic              w_adv;
    logic [STAGES-1:0] r_vld, r_rej;
    logic [15:0]       r_rng [RNG_DLY];
    logic [15:0]       r_ang;
    logic [27:0]       w_prod;
    logic [15:0]       w_ang;
    logic              w_rej;
    logic [15:0]       w_cos_ang;

    logic [lspr_pkg::MAG_W-1:0] w_mag_x, w_mag_y;
    logic                       w_sneg_x, w_sneg_y;
    logic [lspr_pkg::OFF_W-1:0] w_off_x, w_off_y;
    logic                       w_neg_x, w_neg_y;
    logic signed [PW-1:0]       w_pos_x, w_pos_y;
    logic                       w_off_img;

    logic                r_out_valid;
    lspr_pkg::t_out_item r_out, n_out;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rmin   <= 16'd0;
            r_rmax   <= 16'hFFFF;
            r_astart <= 16'd0;
            r_astep  <= 16'd182;
            r_scale  <= 24'd250;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lspr_pkg::CFG_RANGE_MIN:   r_rmin   <= i_cfg_data[15:0];
                lspr_pkg::CFG_RANGE_MAX:   r_rmax   <= i_cfg_data[15:0];
                lspr_pkg::CFG_ANGLE_START: r_astart <= i_cfg_data[15:0];
                lspr_pkg::CFG_ANGLE_STEP:  r_astep  <= i_cfg_data[15:0];
                lspr_pkg::CFG_PIXEL_SCALE: r_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline moves unless a finished result is held by the receiver
    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // stage 1: range window and beam angle
    assign w_prod = {16'd0, i_in.sample_index} * {12'd0, r_astep};
    assign w_ang  = r_astart + w_prod[15:0];
    assign w_rej  = (i_in.range_mm < r_rmin) || (i_in.range_mm > r_rmax);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rej    <= {r_rej[STAGES-2:0], w_rej};
            r_ang    <= w_ang;
            r_rng[0] <= i_in.range_mm;
            for (int i = 1; i < RNG_DLY; i++) begin
                r_rng[i] <= r_rng[i-1];
            end
        end
    end

    // cosine is the sine one quadrant on
    assign w_cos_ang = {r_ang[15:14] + 2'd1, r_ang[13:0]};

    lspr_sine u_sine_x (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_angle (w_cos_ang),
        .o_mag   (w_mag_x),
        .o_neg   (w_sneg_x)
    );

    lspr_sine u_sine_y (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_angle (r_ang),
        .o_mag   (w_mag_y),
        .o_neg   (w_sneg_y)
    );

    lspr_proj u_proj_x (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_range (r_rng[RNG_DLY-1]),
        .i_mag   (w_mag_x),
        .i_neg   (w_sneg_x),
        .i_scale (r_scale),
        .o_off   (w_off_x),
        .o_neg   (w_neg_x)
    );

    lspr_proj u_proj_y (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_range (r_rng[RNG_DLY-1]),
        .i_mag   (w_mag_y),
        .i_neg   (w_sneg_y),
        .i_scale (r_scale),
        .o_off   (w_off_y),
        .o_neg   (w_neg_y)
    );

    // final stage: signed offset around the image center, bounds check
    assign w_pos_x = w_neg_x ? (CENTER - PW'(w_off_x)) : (CENTER + PW'(w_off_x));
    assign w_pos_y = w_neg_y ? (CENTER - PW'(w_off_y)) : (CENTER + PW'(w_off_y));
    assign w_off_img = w_pos_x[PW-1] || (w_pos_x >= LIMIT)
                    || w_pos_y[PW-1] || (w_pos_y >= LIMIT);

    always_comb begin
        n_out = '0;
        if (r_rej[STAGES-1]) begin
            n_out.status = lspr_pkg::STS_REJECT;
        end else if (w_off_img) begin
            n_out.status = lspr_pkg::STS_OFFIMG;
        end else begin
            n_out.status  = lspr_pkg::STS_PLOT;
            n_out.pixel_x = w_pos_x[8:0];
            n_out.pixel_y = w_pos_y[8:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_vld[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

`include "assert_macros.svh"

    `ASSERT_IMPLY(a_no_pix_on_fail, o_valid && (o_out.status != lspr_pkg::STS_PLOT), (o_out.pixel_x == 9'd0) && (o_out.pixel_y == 9'd0), "pixel set on failed status")
    `ASSERT_IMPLY(a_status_code, o_valid, o_out.status != lspr_pkg::STS_RSVD, "reserved status code")
    `ASSERT_CLK(a_freeze_on_stall, (!w_adv |=> $stable(r_vld)), "pipeline moved while stalled")
    `ASSERT_CLK(a_accept_enters, ((i_valid && !o_stall) |=> r_vld[0]), "accepted transaction lost")

endmodule

// ===== tb/lidar_scan_point_rasterizer_unit_checker.sv =====
// Checker for the lidar scan point rasterizer: predicts each pixel result and compares it
`timescale 1ns / 100ps

module lidar_scan_point_rasterizer_unit_checker
    import lspr_pkg::*;
#(
    parameter int IMAGE_SIZE = IMAGE_SIZE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    // quarter-wave sine polynomial, Q16 coefficients
    localparam longint unsigned POLY_A   = 102944;
    localparam longint unsigned POLY_B   = 42047;
    localparam longint unsigned POLY_C   = 4640;
    localparam longint unsigned UNIT_Q16 = 65536;
    localparam logic [14:0]     QUARTER_TURN = 15'd16384;

    logic [15:0] cfg_range_min;
    logic [15:0] cfg_range_max;
    logic [15:0] cfg_angle_start;
    logic [15:0] cfg_angle_step;
    logic [23:0] cfg_pixel_scale;

    t_out_item predicted_points[$];
    int        result_count;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        result_count = 0;
    end

    // |sin| in Q16; the sign is the top angle bit
    function automatic logic [16:0] sine_q16(input logic [15:0] angle);
        logic [14:0]       arg;
        longint unsigned   sq;
        longint unsigned   acc;
        arg = angle[14] ? (QUARTER_TURN - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
        sq  = (longint'(arg) * arg) >> 14;
        acc = (POLY_C * sq) >> 14;
        acc = ((POLY_B - acc) * sq) >> 14;
        acc = ((POLY_A - acc) * arg) >> 14;
        if (acc > UNIT_Q16)
            acc = UNIT_Q16;
        return acc[16:0];
    endfunction

    // signed pixel position along one axis, truncated toward zero, centred
    function automatic longint axis_position(input logic [15:0] mm, input logic [15:0] angle);
        logic [16:0]     mag;
        longint unsigned prod;
        longint          off;
        mag  = sine_q16(angle);
        prod = longint'(mm) * mag * cfg_pixel_scale;
        off  = longint'(prod >> 32);
        if (angle[15])
            off = -off;
        return off + IMAGE_SIZE / 2;
    endfunction

    function automatic t_out_item rasterize_sample(input t_in_item s);
        t_out_item   res;
        logic [15:0] beam;
        logic [31:0] turn;
        longint      px;
        longint      py;
        res = '0;
        if (s.range_mm < cfg_range_min || s.range_mm > cfg_range_max) begin
            res.status = STS_REJECT;
        end else begin
            turn = 32'(cfg_angle_start) + 32'(s.sample_index) * 32'(cfg_angle_step);
            beam = turn[15:0];
            px = axis_position(s.range_mm, beam + 16'(QUARTER_TURN));
            py = axis_position(s.range_mm, beam);
            if (px < 0 || px >= IMAGE_SIZE || py < 0 || py >= IMAGE_SIZE) begin
                res.status = STS_OFFIMG;
            end else begin
                res.status  = STS_PLOT;
                res.pixel_x = px[8:0];
                res.pixel_y = py[8:0];
            end
        end
        return res;
    endfunction

    // append one expected result at the tail of the queue
    task automatic enqueue_point(input t_out_item p);
        predicted_points.insert(predicted_points.size(), p);
    endtask

    task automatic flag_point_error(input string what, input logic [31:0] got,
                                    input logic [31:0] want);
        $display("[%0t] result %0d: %s got %0h expected %0h",
                 $realtime, result_count, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cfg_range_min   = 16'd0;
            cfg_range_max   = 16'd65535;
            cfg_angle_start = 16'd0;
            cfg_angle_step  = 16'd182;
            cfg_pixel_scale = 24'd250;
            predicted_points.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RANGE_MIN:   cfg_range_min   = i_cfg_data[15:0];
                    CFG_RANGE_MAX:   cfg_range_max   = i_cfg_data[15:0];
                    CFG_ANGLE_START: cfg_angle_start = i_cfg_data[15:0];
                    CFG_ANGLE_STEP:  cfg_angle_step  = i_cfg_data[15:0];
                    CFG_PIXEL_SCALE: cfg_pixel_scale = i_cfg_data;
                    default: ;
                endcase
            end
            // retire before predicting so a same-edge input never pairs with this output
            if (i_out_valid && !i_out_stall) begin
                if (predicted_points.size() == 0) begin
                    flag_point_error("unexpected transaction", 32'(i_out_item), 32'd0);
                end else begin
                    want = predicted_points.pop_front();
                    if (i_out_item.status !== want.status)
                        flag_point_error("status", 32'(i_out_item.status), 32'(want.status));
                    if (i_out_item.pixel_x !== want.pixel_x)
                        flag_point_error("pixel_x", 32'(i_out_item.pixel_x), 32'(want.pixel_x));
                    if (i_out_item.pixel_y !== want.pixel_y)
                        flag_point_error("pixel_y", 32'(i_out_item.pixel_y), 32'(want.pixel_y));
                end
                result_count++;
            end
            if (i_in_valid && !i_in_stall)
                enqueue_point(rasterize_sample(i_in_item));
        end
        o_pending = predicted_points.size();
    end

endmodule

// ===== tb/lidar_scan_point_rasterizer_unit_tb.sv =====
// Testbench top for the lidar scan point rasterizer: stimulus, idling and verdict
`timescale 1ns / 100ps

module lidar_scan_point_rasterizer_unit_tb;
    import lspr_pkg::*;

    localparam int IMAGE_SIZE   = IMAGE_SIZE_DEF;
    localparam int QUIET_LIMIT  = 4000;
    localparam int SEGMENTS     = 12;
    localparam int SEG_ITEMS    = 62;
    localparam int SETTLE_TIME  = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_PIXEL_SCALE + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = '1;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_stall;
    t_in_item              i_in       = '0;
    logic                  o_valid;
    logic                  i_stall    = 1'b0;
    t_out_item             o_out;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int fail_count;
    int pending_points;
    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    logic [15:0] win_min = 16'd0;
    logic [15:0] win_max = 16'd65535;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    lidar_scan_point_rasterizer_unit #(.IMAGE_SIZE(IMAGE_SIZE)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    lidar_scan_point_rasterizer_unit_checker #(.IMAGE_SIZE(IMAGE_SIZE)) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_item    (i_in),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_item   (o_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_points)
    );

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog: cycles with no transaction on any port
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_sample(input logic [15:0] mm, input logic [11:0] idx);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= '{range_mm: mm, sample_index: idx};
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain_points();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_points != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // upper data bits of the 16-bit registers carry noise; a stray index write rides along
    task automatic load_config(input logic [15:0] lo, input logic [15:0] hi,
                               input logic [15:0] start, input logic [15:0] step,
                               input logic [23:0] scale);
        write_reg(CFG_RANGE_MIN,   {8'($urandom), lo});
        write_reg(CFG_RANGE_MAX,   {8'($urandom), hi});
        write_reg(CFG_ANGLE_START, {8'($urandom), start});
        write_reg(CFG_ANGLE_STEP,  {8'($urandom), step});
        write_reg(CFG_PIXEL_SCALE, scale);
        write_reg(CFG_IDX_W'($urandom_range(CFG_LAST_UNUSED, CFG_FIRST_UNUSED)),
                  CFG_DATA_W'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        win_min = lo;
        win_max = hi;
    endtask

    task automatic randomize_config();
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] step;
        logic [23:0] scale;
        int          base;
        int          pick;
        hi = 16'($urandom_range(65535, 1000));
        lo = 16'($urandom_range(hi / 2));
        if ($urandom_range(9) == 0) begin
            // inverted window
            lo = hi;
            hi = hi - 16'($urandom_range(999, 1));
        end
        base = 16384000 / int'(hi);
        pick = $urandom_range(9);
        if (pick <= 5)
            scale = 24'(base - base / 16 + $urandom_range(base / 8));
        else if (pick == 6)
            scale = 24'($urandom);
        else if (pick == 7)
            scale = '0;
        else if (pick == 8)
            scale = '1;
        else
            scale = 24'(base * 2);
        step = ($urandom_range(3) == 0) ? 16'($urandom_range(400)) : 16'($urandom);
        load_config(lo, hi, 16'($urandom), step, scale);
    endtask

    function automatic logic [15:0] pick_range_mm();
        int pick;
        pick = $urandom_range(9);
        if (pick <= 6)
            return 16'($urandom_range(win_max, win_min));
        else if (pick == 7)
            return 16'($urandom);
        else if (pick == 8)
            return $urandom_range(1) ? win_min - 16'($urandom_range(1)) :
                                       win_max + 16'($urandom_range(1));
        else
            return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endfunction

    function automatic logic [11:0] pick_index();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0)
            return 12'd0;
        else if (pick == 1)
            return 12'hFFF;
        else
            return 12'($urandom);
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults after reset
        push_sample(16'd0, 12'd0);
        push_sample(16'hFFFF, 12'd0);
        push_sample(16'hFFFF, 12'hFFF);
        push_sample(16'd1, 12'd1);
        push_sample(16'd40000, 12'd2048);
        push_sample(16'd12345, 12'd1000);
        drain_points();

        // quadrant boundaries at full range, image edges, index wrap
        load_config(16'd0, 16'hFFFF, 16'd0, 16'd16384, 24'd250);
        for (int q = 0; q < 4; q++)
            push_sample(16'hFFFF, 12'(q));
        push_sample(16'hFFFF, 12'hFFF);
        push_sample(16'd30000, 12'd1);
        push_sample(16'd30000, 12'd2);
        drain_points();

        // window edges with the largest scale and step, mostly off image
        load_config(16'd1000, 16'd2000, 16'd8192, 16'hFFFF, 24'hFFFFFF);
        push_sample(16'd999, 12'hFFF);
        push_sample(16'd1000, 12'hFFF);
        push_sample(16'd2000, 12'd0);
        push_sample(16'd2001, 12'd7);
        drain_points();

        // minimum above maximum rejects everything
        load_config(16'd5000, 16'd4000, 16'd0, 16'd182, 24'd250);
        push_sample(16'd4500, 12'd5);
        push_sample(16'd0, 12'd0);
        push_sample(16'hFFFF, 12'hFFF);
        drain_points();

        // zero scale lands on the centre pixel
        load_config(16'd0, 16'hFFFF, 16'hFFFF, 16'd1234, 24'd0);
        push_sample(16'hFFFF, 12'($urandom));
        push_sample(16'd777, 12'($urandom));
        push_sample(16'd0, 12'($urandom));
        drain_points();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            randomize_config();
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 81; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 81; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            for (int n = 0; n < SEG_ITEMS; n++)
                push_sample(pick_range_mm(), pick_index());
            drain_points();
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (SETTLE_TIME) @(negedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/lspr_pkg.sv
design/lspr_sine.sv
design/lspr_proj.sv
design/lidar_scan_point_rasterizer_unit.sv
tb/lidar_scan_point_rasterizer_unit_checker.sv
tb/lidar_scan_point_rasterizer_unit_tb.sv
